/* hw/rtl/ssg_pkg.sv */
// shared types, constants and the per-entry decision function for session_sequence_guard
// used by ssg_cfg, ssg_cell and the top level; no dependencies
package ssg_pkg;

	localparam int MAX_SESSIONS = 256;

	localparam int SID_W   = 31;
	localparam int SEQ_W   = 32;
	localparam int RSN_W   = 16;
	localparam int EVT_W   = 40;
	localparam int VRD_W   = 3;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam logic [SEQ_W-1:0] THR_RST       = SEQ_W'(5000);
	localparam logic [RSN_W-1:0] RSN_RST       = RSN_W'(9203);
	localparam logic [EVT_W-1:0] FIRST_EVT_RST = EVT_W'(900000000);

	localparam logic [SEQ_W-1:0] SEQ_ONE = SEQ_W'(1);
	localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_THR   = 2'd0,
		REG_RSN   = 2'd1,
		REG_FIRST = 2'd2
	} reg_idx_t;

	typedef enum logic [VRD_W-1:0] {
		V_INSEQ  = 3'd0,
		V_RESYNC = 3'd1,
		V_GAP    = 3'd2,
		V_DUP    = 3'd3,
		V_FULL   = 3'd4,
		V_OVF    = 3'd5
	} verdict_t;

	typedef struct packed {
		logic [SEQ_W-1:0] thr;
		logic [RSN_W-1:0] rsn;
	} cfg_t;

	typedef struct packed {
		logic             ld;
		logic [EVT_W-1:0] val;
	} evt_ld_t;

	// one message walking down the chain of entries
	typedef struct packed {
		logic             vld;
		logic [SID_W-1:0] sid;
		logic [SEQ_W-1:0] seq;
		logic [RSN_W-1:0] rsn;
		logic             marker;
		logic             found;
		verdict_t         verdict;
		logic [SEQ_W-1:0] exp_before;
	} qry_t;

	typedef struct packed {
		verdict_t         verdict;
		logic [SEQ_W-1:0] new_exp;
	} dec_t;

	function automatic dec_t ssg_decide(
		input logic [SEQ_W-1:0] seq,
		input logic [SEQ_W-1:0] expv,
		input logic [RSN_W-1:0] rsn,
		input logic             marker,
		input cfg_t             cfg
	);
		dec_t d;
		logic cand;
		cand = ((seq == SEQ_ONE) && (expv > cfg.thr)) ||
			((rsn == cfg.rsn) && (seq <= expv)) ||
			(marker && (seq == SEQ_ONE));
		d.new_exp = expv;
		if (seq == expv) begin
			if (expv == SEQ_MAX) begin
				d.verdict = V_OVF;
			end else begin
				d.verdict = V_INSEQ;
				d.new_exp = expv + SEQ_ONE;
			end
		end else if (cand) begin
			if (seq == SEQ_MAX) begin
				d.verdict = V_OVF;
			end else begin
				d.verdict = V_RESYNC;
				d.new_exp = seq + SEQ_ONE;
			end
		end else if (seq > expv) begin
			d.verdict = V_GAP;
		end else begin
			d.verdict = V_DUP;
		end
		return d;
	endfunction

endpackage

/* hw/rtl/ssg_cfg.sv */
// apb register file: reset gap threshold, reset reason code, first event id
// depends on ssg_pkg
module ssg_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssg_pkg::PADDR_W-1:0]   paddr,
	input  logic [ssg_pkg::PDATA_W-1:0]   pwdata,
	output logic [ssg_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output ssg_pkg::cfg_t                 cfg,
	output ssg_pkg::evt_ld_t              evt_ld
);

	logic [ssg_pkg::SEQ_W-1:0] thr_q;
	logic [ssg_pkg::RSN_W-1:0] rsn_q;
	logic [ssg_pkg::EVT_W-1:0] first_q;
	logic                      wr;
	ssg_pkg::reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = ssg_pkg::reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= ssg_pkg::THR_RST;
			rsn_q   <= ssg_pkg::RSN_RST;
			first_q <= ssg_pkg::FIRST_EVT_RST;
		end else if (wr) begin
			case (idx)
				ssg_pkg::REG_THR:   thr_q   <= pwdata[ssg_pkg::SEQ_W-1:0];
				ssg_pkg::REG_RSN:   rsn_q   <= pwdata[ssg_pkg::RSN_W-1:0];
				ssg_pkg::REG_FIRST: first_q <= pwdata[ssg_pkg::EVT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			ssg_pkg::REG_THR:   prdata = ssg_pkg::PDATA_W'(thr_q);
			ssg_pkg::REG_RSN:   prdata = ssg_pkg::PDATA_W'(rsn_q);
			ssg_pkg::REG_FIRST: prdata = ssg_pkg::PDATA_W'(first_q);
			default:            prdata = '0;
		endcase
	end

	assign cfg.thr = thr_q;
	assign cfg.rsn = rsn_q;

	// writing the first id also reloads the event counter
	assign evt_ld.ld  = wr && (idx == ssg_pkg::REG_FIRST);
	assign evt_ld.val = pwdata[ssg_pkg::EVT_W-1:0];

endmodule

/* hw/rtl/ssg_cell.sv */
// one session entry of the chain: key, expected sequence and in-use flag
// checks the passing message, updates itself, registers the message onward; depends on ssg_pkg
module ssg_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  ssg_pkg::cfg_t cfg,
	input  ssg_pkg::qry_t qry_i,
	output ssg_pkg::qry_t qry_o
);

	logic                      used_q;
	logic [ssg_pkg::SID_W-1:0] key_q;
	logic [ssg_pkg::SEQ_W-1:0] exp_q;
	logic                      hit;
	logic                      keep;
	logic [ssg_pkg::SEQ_W-1:0] expv;
	ssg_pkg::dec_t             dec;
	ssg_pkg::qry_t             nxt;
	ssg_pkg::qry_t             qry_s1;
	logic                      vld_s1;

	// used entries are contiguous, so a free cell reached by an unmatched message allocates
	assign hit  = qry_i.vld && !qry_i.found && (!used_q || (key_q == qry_i.sid));
	assign expv = used_q ? exp_q : ssg_pkg::SEQ_ONE;
	assign dec  = ssg_pkg::ssg_decide(qry_i.seq, expv, qry_i.rsn, qry_i.marker, cfg);
	assign keep = hit && (dec.verdict != ssg_pkg::V_OVF);

	always_comb begin
		nxt = qry_i;
		if (hit) begin
			nxt.found      = 1'b1;
			nxt.verdict    = dec.verdict;
			nxt.exp_before = expv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= qry_i.vld;
			if (keep) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		qry_s1 <= nxt;
		if (keep) begin
			key_q <= qry_i.sid;
			exp_q <= dec.new_exp;
		end
	end

	always_comb begin
		qry_o     = qry_s1;
		qry_o.vld = vld_s1;
	end

endmodule

/* hw/rtl/session_sequence_guard.sv */
// session_sequence_guard: per-session sequence checker built as a chain of entry cells
// path: start passes one register per cell, the last cell feeding the result register that
// drives done; throughput: one message per cycle, busy stays low, set by the cell chain
// reset: all entries free, event counter at first_event_id, registers at their reset values
// results come out in message order as single-cycle done strobes; the receiver cannot stall
module session_sequence_guard (
	input  logic                          clk,
	input  logic                          arst_n,
	// message command
	input  logic                          start,
	output logic                          busy,
	input  logic [ssg_pkg::SID_W-1:0]     session_id,
	input  logic [ssg_pkg::SEQ_W-1:0]     seq_num,
	input  logic [ssg_pkg::RSN_W-1:0]     msg_reason,
	input  logic                          reset_marker,
	// result
	output logic                          done,
	output logic [ssg_pkg::VRD_W-1:0]     verdict,
	output logic [ssg_pkg::EVT_W-1:0]     event_id,
	output logic [ssg_pkg::SEQ_W-1:0]     expected_before,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssg_pkg::PADDR_W-1:0]   paddr,
	input  logic [ssg_pkg::PDATA_W-1:0]   pwdata,
	output logic [ssg_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	ssg_pkg::cfg_t             cfg;
	ssg_pkg::evt_ld_t          evt_ld;
	ssg_pkg::qry_t             chain [ssg_pkg::MAX_SESSIONS+1];
	ssg_pkg::qry_t             tail;
	ssg_pkg::verdict_t         fin_verdict;
	logic                      is_event;
	logic [ssg_pkg::EVT_W-1:0] next_ev_q;
	logic                      done_q;
	ssg_pkg::verdict_t         verdict_q;
	logic [ssg_pkg::EVT_W-1:0] event_id_q;
	logic [ssg_pkg::SEQ_W-1:0] exp_before_q;

	// the chain takes a new message every cycle, so it never holds start off
	assign busy = 1'b0;

	ssg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.evt_ld  (evt_ld)
	);

	// head of the chain: the message as it comes in, not yet matched
	always_comb begin
		chain[0].vld        = start && !busy;
		chain[0].sid        = session_id;
		chain[0].seq        = seq_num;
		chain[0].rsn        = msg_reason;
		chain[0].marker     = reset_marker;
		chain[0].found      = 1'b0;
		chain[0].verdict    = ssg_pkg::V_INSEQ;
		chain[0].exp_before = '0;
	end

	// each cell holds one session; a message meets the cells in table order, and
	// messages stay in order, so each one sees every earlier update
	for (genvar g = 0; g < ssg_pkg::MAX_SESSIONS; g++) begin : g_cell
		ssg_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg),
			.qry_i  (chain[g]),
			.qry_o  (chain[g+1])
		);
	end

	assign tail = chain[ssg_pkg::MAX_SESSIONS];

	// a message that left the chain unmatched found no free entry
	assign fin_verdict = tail.found ? tail.verdict : ssg_pkg::V_FULL;
	assign is_event    = tail.vld && ((fin_verdict == ssg_pkg::V_RESYNC) ||
		(fin_verdict == ssg_pkg::V_GAP) || (fin_verdict == ssg_pkg::V_DUP));

	// event id counter, wraps at 2^40; config writes must happen only while idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ev_q <= ssg_pkg::FIRST_EVT_RST;
		end else if (evt_ld.ld) begin
			next_ev_q <= evt_ld.val;
		end else if (is_event) begin
			next_ev_q <= next_ev_q + ssg_pkg::EVT_W'(1);
		end
	end

	// result register: one transfer per message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.vld;
		end
	end

	always_ff @(posedge clk) begin
		verdict_q    <= fin_verdict;
		event_id_q   <= is_event ? next_ev_q : '0;
		exp_before_q <= tail.found ? tail.exp_before : '0;
	end

	assign done            = done_q;
	assign verdict         = verdict_q;
	assign event_id        = event_id_q;
	assign expected_before = exp_before_q;

endmodule
